>>> hw/rtl/dqsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqsc_pkg
// Shared codes, widths and record types of the dwell qualified state confirmer.
// ----------------------------------------------------------------------------
package dqsc_pkg;

  // Width of the time arithmetic; the timestamp port is 32 bits wide.
  localparam int TIME_BITS  = 32;
  localparam int STATE_BITS = 4;
  localparam int DWELL_BITS = 16;
  localparam int CFG_IDX_BITS = 3;

  typedef logic [STATE_BITS-1:0] state_code_t;
  typedef logic [TIME_BITS-1:0]  time_t;
  typedef logic [DWELL_BITS-1:0] dwell_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  // Activity state codes.
  localparam state_code_t ST_UNKNOWN  = 4'd0;
  localparam state_code_t ST_REST     = 4'd1;
  localparam state_code_t ST_SLEEP    = 4'd2;
  localparam state_code_t ST_WALK     = 4'd3;
  localparam state_code_t ST_TROT     = 4'd4;
  localparam state_code_t ST_RUN      = 4'd5;
  localparam state_code_t ST_PLAY     = 4'd6;
  localparam state_code_t ST_PASSIVE  = 4'd7;
  localparam state_code_t ST_NOT_WORN = 4'd8;

  // Configuration register indexes.
  localparam cfg_idx_t REG_FINE_STATES_ON   = 3'd0;
  localparam cfg_idx_t REG_RUN_STATE_ON     = 3'd1;
  localparam cfg_idx_t REG_PASSIVE_AS_REST  = 3'd2;
  localparam cfg_idx_t REG_DWELL_TO_REST_MS = 3'd3;
  localparam cfg_idx_t REG_DWELL_WAKE_MS    = 3'd4;
  localparam cfg_idx_t REG_DWELL_FAST_MS    = 3'd5;
  localparam cfg_idx_t REG_DWELL_DEFAULT_MS = 3'd6;

  // Register values after reset.
  localparam dwell_t RST_DWELL_TO_REST = 16'd3500;
  localparam dwell_t RST_DWELL_WAKE    = 16'd2500;
  localparam dwell_t RST_DWELL_FAST    = 16'd1000;
  localparam dwell_t RST_DWELL_DEFAULT = 16'd2000;

  // Configuration as seen by the update logic.
  typedef struct packed {
    logic   fine_states_on;
    logic   run_state_on;
    logic   passive_as_rest;
    dwell_t dwell_to_rest;
    dwell_t dwell_wake;
    dwell_t dwell_fast;
    dwell_t dwell_default;
  } dqsc_cfg_t;

  // Tracking state carried from one beat to the next.
  typedef struct packed {
    state_code_t confirmed;
    state_code_t pending;
    time_t       pending_start;
    state_code_t shown;
    time_t       shown_start;
  } dqsc_state_t;

endpackage

>>> hw/rtl/dqsc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqsc_core
// Next-state logic for one beat: dwell qualification and display mapping.
// ----------------------------------------------------------------------------
module dqsc_core (
  input  dqsc_pkg::dqsc_cfg_t   cfg,
  input  dqsc_pkg::dqsc_state_t cur,
  input  dqsc_pkg::state_code_t target_raw,
  input  logic [31:0]           now_raw,
  output dqsc_pkg::dqsc_state_t nxt,
  output logic                  changed
);
  import dqsc_pkg::*;

  state_code_t target;
  time_t       now;
  time_t       elapsed;
  dwell_t      dwell;
  state_code_t conf_new;
  state_code_t pend_new;
  time_t       pend_start_new;
  state_code_t disp;

  // Codes beyond not worn count as unknown; time is taken modulo its width.
  always_comb begin
    target = (target_raw > ST_NOT_WORN) ? ST_UNKNOWN : target_raw;
    now    = time_t'(now_raw);
  end

  // Dwell for the pair (confirmed, candidate), first matching rule wins.
  always_comb begin
    if (cur.confirmed == ST_UNKNOWN || cur.confirmed == target ||
        target == ST_NOT_WORN) begin
      dwell = '0;
    end else if (target inside {ST_REST, ST_SLEEP}) begin
      dwell = cfg.dwell_to_rest;
    end else if ((cur.confirmed inside {ST_REST, ST_SLEEP, ST_NOT_WORN}) &&
                 (target inside {ST_WALK, ST_TROT, ST_RUN})) begin
      dwell = cfg.dwell_wake;
    end else if (target inside {ST_PLAY, ST_RUN}) begin
      dwell = cfg.dwell_fast;
    end else if ((cur.confirmed inside {ST_PLAY, ST_RUN}) && target == ST_WALK) begin
      dwell = cfg.dwell_fast;
    end else begin
      dwell = cfg.dwell_default;
    end
  end

  // Wrapping time since the pending candidate first appeared.
  assign elapsed = now - cur.pending_start;

  // Confirmation and pending candidate update.
  always_comb begin
    pend_new       = cur.pending;
    pend_start_new = cur.pending_start;
    conf_new       = cur.confirmed;
    if (cur.confirmed == ST_UNKNOWN) begin
      conf_new       = target;
      pend_new       = target;
      pend_start_new = now;
    end else if (target == cur.confirmed || target != cur.pending) begin
      pend_new       = target;
      pend_start_new = now;
    end else if (elapsed >= time_t'(dwell)) begin
      conf_new = target;
    end
  end

  // Display mapping of the newly confirmed state.
  always_comb begin
    disp = conf_new;
    if (!cfg.fine_states_on) begin
      case (conf_new)
        ST_RUN:          disp = cfg.run_state_on ? ST_RUN : ST_WALK;
        ST_TROT, ST_PLAY: disp = ST_WALK;
        ST_PASSIVE:      disp = cfg.passive_as_rest ? ST_REST : ST_PASSIVE;
        default:         disp = conf_new;
      endcase
    end
  end

  // Display change tracking; an unknown display restarts its time every beat.
  always_comb begin
    changed           = (disp != cur.shown);
    nxt.confirmed     = conf_new;
    nxt.pending       = pend_new;
    nxt.pending_start = pend_start_new;
    nxt.shown         = cur.shown;
    nxt.shown_start   = cur.shown_start;
    if (cur.shown == ST_UNKNOWN || changed) begin
      nxt.shown       = disp;
      nxt.shown_start = now;
    end
  end

endmodule

>>> hw/rtl/dwell_qualified_state_confirmer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwell_qualified_state_confirmer
// Confirms proposed activity states after a pair-dependent dwell and reports
// changes of the coarser display state.
// ----------------------------------------------------------------------------
// The block accepts one beat per clock cycle while results are taken. Each
// accepted beat updates the tracking state in a single register stage, and
// its result is presented on the out_ channel on the next cycle, held until
// taken. A new input beat is taken in the same cycle that the pending result
// is taken, so throughput is one beat per cycle while out_ready stays high.
// Configuration writes take effect at once and are meant to be made while no
// beat is in flight.
module dwell_qualified_state_confirmer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dqsc_pkg::state_code_t in_target_state,
  input  logic [31:0]           in_now_ms,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dqsc_pkg::state_code_t out_confirmed_state,
  output dqsc_pkg::state_code_t out_display_state,
  output logic                  out_display_changed,
  output logic [31:0]           out_display_since_ms,
  input  logic                  cfg_we,
  input  dqsc_pkg::cfg_idx_t    cfg_index,
  input  logic [15:0]           cfg_wdata
);
  import dqsc_pkg::*;

  dqsc_cfg_t   cfg_r;
  dqsc_state_t st_r;
  dqsc_state_t st_nxt;
  logic        changed_nxt;
  logic        changed_r;
  logic        out_valid_r;
  logic        in_fire;

  // Accept a new beat whenever the result register is empty or being drained.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fine_states_on  <= 1'b0;
      cfg_r.run_state_on    <= 1'b1;
      cfg_r.passive_as_rest <= 1'b0;
      cfg_r.dwell_to_rest   <= RST_DWELL_TO_REST;
      cfg_r.dwell_wake      <= RST_DWELL_WAKE;
      cfg_r.dwell_fast      <= RST_DWELL_FAST;
      cfg_r.dwell_default   <= RST_DWELL_DEFAULT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FINE_STATES_ON:   cfg_r.fine_states_on  <= cfg_wdata[0];
        REG_RUN_STATE_ON:     cfg_r.run_state_on    <= cfg_wdata[0];
        REG_PASSIVE_AS_REST:  cfg_r.passive_as_rest <= cfg_wdata[0];
        REG_DWELL_TO_REST_MS: cfg_r.dwell_to_rest   <= cfg_wdata;
        REG_DWELL_WAKE_MS:    cfg_r.dwell_wake      <= cfg_wdata;
        REG_DWELL_FAST_MS:    cfg_r.dwell_fast      <= cfg_wdata;
        REG_DWELL_DEFAULT_MS: cfg_r.dwell_default   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Per-beat update logic.
  dqsc_core u_core (
    .cfg        (cfg_r),
    .cur        (st_r),
    .target_raw (in_target_state),
    .now_raw    (in_now_ms),
    .nxt        (st_nxt),
    .changed    (changed_nxt)
  );

  // Tracking state, which doubles as the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.confirmed     <= ST_UNKNOWN;
      st_r.pending       <= ST_UNKNOWN;
      st_r.pending_start <= '0;
      st_r.shown         <= ST_UNKNOWN;
      st_r.shown_start   <= '0;
      changed_r          <= 1'b0;
      out_valid_r        <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r      <= st_nxt;
        changed_r <= changed_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result channel.
  assign out_valid            = out_valid_r;
  assign out_confirmed_state  = st_r.confirmed;
  assign out_display_state    = st_r.shown;
  assign out_display_changed  = changed_r;
  assign out_display_since_ms = 32'(st_r.shown_start);

`ifndef SYNTHESIS
  // An accepted beat always yields a result on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid)
    else $error("result missing after accepted beat");

  // Confirmed state stays within the defined codes.
  a_conf_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_confirmed_state <= ST_NOT_WORN)
    else $error("confirmed state out of range");

  // A display change is stamped with the time of the beat that caused it.
  a_change_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (!out_display_changed || out_display_since_ms == $past(in_now_ms)))
    else $error("display change carries wrong timestamp");

  // With merging on, trot and play never reach the display.
  a_merge: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !cfg_r.fine_states_on && !cfg_we) |=>
      (out_display_state != ST_TROT && out_display_state != ST_PLAY))
    else $error("unmerged state shown on display");
`endif

endmodule

>>> bench/dqsc_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqsc_result_checker
// Watches the ports of the dwell qualified state confirmer, tracks its
// configuration and state on its own, and compares every result beat with
// the outcome predicted for the input beat that caused it.
// ----------------------------------------------------------------------------
module dqsc_result_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  dqsc_pkg::state_code_t in_target_state,
  input  logic [31:0]           in_now_ms,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  dqsc_pkg::state_code_t out_confirmed_state,
  input  dqsc_pkg::state_code_t out_display_state,
  input  logic                  out_display_changed,
  input  logic [31:0]           out_display_since_ms,
  input  logic                  cfg_we,
  input  dqsc_pkg::cfg_idx_t    cfg_index,
  input  logic [15:0]           cfg_wdata,
  output int                    n_fail,
  output int                    n_waiting
);
  import dqsc_pkg::*;

  // One predicted result beat.
  typedef struct packed {
    state_code_t confirmed;
    state_code_t display;
    logic        changed;
    logic [31:0] since;
  } state_report_t;

  // Copy of the configuration registers.
  logic   fine_on;
  logic   run_on;
  logic   psv_rest;
  dwell_t dw_rest;
  dwell_t dw_wake;
  dwell_t dw_fast;
  dwell_t dw_dflt;

  // Copy of the tracking state.
  state_code_t conf_st;
  state_code_t cand_st;
  time_t       cand_since;
  state_code_t disp_st;
  time_t       disp_since;

  state_report_t due_results[$];
  int            miss_cnt = 0;

  // Dwell that a candidate must persist before it replaces the confirmed state.
  function automatic dwell_t hold_needed(state_code_t from, state_code_t to);
    if (from == ST_UNKNOWN || from == to || to == ST_NOT_WORN) return '0;
    if (to == ST_REST || to == ST_SLEEP) return dw_rest;
    if ((from == ST_REST || from == ST_SLEEP || from == ST_NOT_WORN) &&
        (to == ST_WALK || to == ST_TROT || to == ST_RUN)) return dw_wake;
    if (to == ST_PLAY || to == ST_RUN) return dw_fast;
    if ((from == ST_PLAY || from == ST_RUN) && to == ST_WALK) return dw_fast;
    return dw_dflt;
  endfunction

  // Coarse display code of a confirmed state under the merge flags.
  function automatic state_code_t shown_code(state_code_t s);
    if (fine_on) return s;
    if (s == ST_RUN) return run_on ? ST_RUN : ST_WALK;
    if (s == ST_TROT || s == ST_PLAY) return ST_WALK;
    if (s == ST_PASSIVE) return psv_rest ? ST_REST : ST_PASSIVE;
    return s;
  endfunction

  // Advances the tracking state by one input beat and returns its result.
  function automatic state_report_t confirm_and_map(state_code_t raw, time_t now);
    state_code_t   tgt;
    state_code_t   view;
    time_t         elapsed;
    state_report_t r;
    tgt = (raw > ST_NOT_WORN) ? ST_UNKNOWN : raw;
    r.changed = 1'b0;
    if (conf_st == ST_UNKNOWN) begin
      conf_st    = tgt;
      cand_st    = tgt;
      cand_since = now;
    end else if (tgt == conf_st || tgt != cand_st) begin
      cand_st    = tgt;
      cand_since = now;
    end else begin
      // The difference wraps, so a timestamp that went backwards looks old.
      elapsed = now - cand_since;
      if (elapsed >= time_t'(hold_needed(conf_st, tgt))) conf_st = tgt;
    end
    view = shown_code(conf_st);
    // While nothing is shown yet the start time follows every beat.
    if (disp_st == ST_UNKNOWN || view != disp_st) begin
      r.changed  = (view != disp_st);
      disp_st    = view;
      disp_since = now;
    end
    r.confirmed = conf_st;
    r.display   = disp_st;
    r.since     = 32'(disp_since);
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      miss_cnt++;
      $display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
    end
  endtask

  // Track configuration writes, check result beats, predict input beats.
  always @(posedge clk) begin
    state_report_t got;
    state_report_t want;
    if (!rst_n) begin
      fine_on    = 1'b0;
      run_on     = 1'b1;
      psv_rest   = 1'b0;
      dw_rest    = RST_DWELL_TO_REST;
      dw_wake    = RST_DWELL_WAKE;
      dw_fast    = RST_DWELL_FAST;
      dw_dflt    = RST_DWELL_DEFAULT;
      conf_st    = ST_UNKNOWN;
      cand_st    = ST_UNKNOWN;
      cand_since = '0;
      disp_st    = ST_UNKNOWN;
      disp_since = '0;
      due_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FINE_STATES_ON:   fine_on  = cfg_wdata[0];
          REG_RUN_STATE_ON:     run_on   = cfg_wdata[0];
          REG_PASSIVE_AS_REST:  psv_rest = cfg_wdata[0];
          REG_DWELL_TO_REST_MS: dw_rest  = cfg_wdata;
          REG_DWELL_WAKE_MS:    dw_wake  = cfg_wdata;
          REG_DWELL_FAST_MS:    dw_fast  = cfg_wdata;
          REG_DWELL_DEFAULT_MS: dw_dflt  = cfg_wdata;
          default: ;
        endcase
      end
      // A result beat leaves before the input beat of the same edge is added.
      if (out_valid && out_ready) begin
        got = {out_confirmed_state, out_display_state, out_display_changed,
               out_display_since_ms};
        if (due_results.size() == 0) begin
          miss_cnt++;
          $display("%0t: result beat expected none actual %h", $time, got);
        end else begin
          want = due_results.pop_front();
          check_field("confirmed_state", 32'(want.confirmed), 32'(got.confirmed));
          check_field("display_state", 32'(want.display), 32'(got.display));
          check_field("display_changed", 32'(want.changed), 32'(got.changed));
          check_field("display_since_ms", want.since, got.since);
        end
      end
      if (in_valid && in_ready)
        due_results.push_back(confirm_and_map(in_target_state, time_t'(in_now_ms)));
    end
    n_fail    <= miss_cnt;
    n_waiting <= due_results.size();
  end

endmodule

>>> bench/dwell_qualified_state_confirmer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwell_qualified_state_confirmer_tb
// Drives directed and random state proposals with randomly idling sender and
// receiver through several register settings; a checker compares results.
// ----------------------------------------------------------------------------
module dwell_qualified_state_confirmer_tb;
  import dqsc_pkg::*;

  // Codes outside the state range, which the block reads as unknown.
  localparam state_code_t ST_BAD_LOW  = 4'd9;
  localparam state_code_t ST_BAD_HIGH = 4'd15;
  // Index past the last register; writes to it must have no effect.
  localparam cfg_idx_t    REG_UNUSED  = 3'd7;
  localparam int N_PHASES      = 8;
  localparam int PHASE_ITEMS   = 80;
  localparam int MAX_WAIT      = 16;
  // Margin after the last result for a stray late beat.
  localparam int SETTLE_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  state_code_t in_target_state;
  logic [31:0] in_now_ms;
  logic        out_valid;
  logic        out_ready;
  state_code_t out_confirmed_state;
  state_code_t out_display_state;
  logic        out_display_changed;
  logic [31:0] out_display_since_ms;
  logic        cfg_we;
  cfg_idx_t    cfg_index;
  logic [15:0] cfg_wdata;
  int          n_fail;
  int          n_waiting;

  // Dwells currently loaded, used to aim timestamp steps near the thresholds.
  dwell_t      cur_rest;
  dwell_t      cur_wake;
  dwell_t      cur_fast;
  dwell_t      cur_dflt;
  time_t       t_now;
  logic        no_idle;

  always #6 clk = ~clk;

  dwell_qualified_state_confirmer i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_target_state      (in_target_state),
    .in_now_ms            (in_now_ms),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_confirmed_state  (out_confirmed_state),
    .out_display_state    (out_display_state),
    .out_display_changed  (out_display_changed),
    .out_display_since_ms (out_display_since_ms),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  dqsc_result_checker i_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_target_state      (in_target_state),
    .in_now_ms            (in_now_ms),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_confirmed_state  (out_confirmed_state),
    .out_display_state    (out_display_state),
    .out_display_changed  (out_display_changed),
    .out_display_since_ms (out_display_since_ms),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .n_fail               (n_fail),
    .n_waiting            (n_waiting)
  );

  // Mostly valid state codes, now and then one out of range.
  function automatic state_code_t pick_state();
    if ($urandom_range(0, 9) == 0) return state_code_t'($urandom_range(9, 15));
    return state_code_t'($urandom_range(0, 8));
  endfunction

  // Half the dwells short enough for random steps to cross them often.
  function automatic dwell_t pick_dwell();
    if ($urandom_range(0, 1) == 0) return dwell_t'($urandom_range(0, 3000));
    return dwell_t'($urandom_range(0, 65535));
  endfunction

  // Timestamp advance: short, near a dwell edge, medium, or an arbitrary jump.
  function automatic time_t next_step();
    dwell_t d;
    case ($urandom_range(0, 3))
      0:       d = cur_rest;
      1:       d = cur_wake;
      2:       d = cur_fast;
      default: d = cur_dflt;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2:    return time_t'($urandom_range(0, 300));
      3, 4, 5, 6: return time_t'(d) + time_t'($urandom_range(0, 4)) - time_t'(2);
      7, 8:       return time_t'($urandom_range(0, 4000));
      default:    return time_t'($urandom());
    endcase
  endfunction

  // Offers one input beat after a random gap and waits for its acceptance.
  task automatic send_beat(input state_code_t tgt, input time_t ts);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_target_state <= tgt;
    in_now_ms       <= ts;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Holds the sender until every predicted result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes every register, plus the unused index, with junk in unused bits.
  task automatic load_config(input logic fine, input logic run, input logic psv,
                             input dwell_t d_rest, input dwell_t d_wake,
                             input dwell_t d_fast, input dwell_t d_dflt);
    logic [15:0] vals [8];
    logic [31:0] junk;
    junk = $urandom();
    vals[REG_FINE_STATES_ON]   = {junk[14:0], fine};
    vals[REG_RUN_STATE_ON]     = {junk[15:1], run};
    vals[REG_PASSIVE_AS_REST]  = {junk[16:2], psv};
    vals[REG_DWELL_TO_REST_MS] = d_rest;
    vals[REG_DWELL_WAKE_MS]    = d_wake;
    vals[REG_DWELL_FAST_MS]    = d_fast;
    vals[REG_DWELL_DEFAULT_MS] = d_dflt;
    vals[REG_UNUSED]           = junk[31:16];
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we   <= 1'b0;
    cur_rest = d_rest;
    cur_wake = d_wake;
    cur_fast = d_fast;
    cur_dflt = d_dflt;
  endtask

  // Receiver: random stall before each result beat.
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      repeat (stall) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Stimulus and verdict.
  initial begin
    state_code_t tgt;
    logic [2:0]  flags;
    int          run_len;
    int          n_sent;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_target_state <= ST_UNKNOWN;
    in_now_ms       <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_FINE_STATES_ON;
    cfg_wdata       <= '0;
    no_idle  = 1'b0;
    cur_rest = RST_DWELL_TO_REST;
    cur_wake = RST_DWELL_WAKE;
    cur_fast = RST_DWELL_FAST;
    cur_dflt = RST_DWELL_DEFAULT;
    t_now    = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk through the rules under the reset configuration.
    // Nothing confirmed yet: out-of-range and unknown codes keep it unknown.
    send_beat(ST_BAD_HIGH, 32'd0);
    send_beat(ST_BAD_LOW, 32'hFFFF_FFFF);
    send_beat(ST_UNKNOWN, 32'd5);
    send_beat(ST_REST, 32'd10);
    // Wake dwell: one short, then exactly met.
    send_beat(ST_WALK, 32'd100);
    send_beat(ST_WALK, 32'd2599);
    send_beat(ST_WALK, 32'd2600);
    send_beat(ST_TROT, 32'd3000);
    send_beat(ST_TROT, 32'd5000);
    send_beat(ST_RUN, 32'd5100);
    send_beat(ST_RUN, 32'd6100);
    send_beat(ST_WALK, 32'd6200);
    send_beat(ST_WALK, 32'd7200);
    send_beat(ST_PLAY, 32'd7300);
    send_beat(ST_PLAY, 32'd8300);
    send_beat(ST_PASSIVE, 32'd8400);
    send_beat(ST_PASSIVE, 32'd10400);
    send_beat(ST_NOT_WORN, 32'd10500);
    send_beat(ST_NOT_WORN, 32'd10500);
    // Sleep candidate confirmed across the timestamp wrap.
    send_beat(ST_SLEEP, 32'hFFFF_F000);
    send_beat(ST_SLEEP, 32'h0000_0A00);
    send_beat(ST_SLEEP, 32'h0000_0A80);
    // A new candidate interrupted before its dwell.
    send_beat(ST_TROT, 32'h0000_0B00);
    send_beat(ST_REST, 32'h0000_0B10);
    t_now = 32'h0000_0B10;
    drain_results();

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < N_PHASES; phase++) begin
      flags = 3'($urandom());
      case (phase)
        0: load_config(1'b0, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
        1: load_config(1'b1, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: load_config(flags[0], flags[1], flags[2], pick_dwell(),
                             pick_dwell(), pick_dwell(), pick_dwell());
      endcase
      no_idle = (phase == 3);
      n_sent  = 0;
      while (n_sent < PHASE_ITEMS) begin
        // A run of one candidate so that dwells can elapse.
        tgt     = pick_state();
        run_len = $urandom_range(1, 6);
        repeat (run_len) begin
          t_now = t_now + next_step();
          send_beat(tgt, t_now);
        end
        n_sent += run_len;
        // Occasional stray proposal that breaks the run.
        if ($urandom_range(0, 4) == 0) begin
          t_now = t_now + next_step();
          send_beat(pick_state(), t_now);
          n_sent++;
        end
      end
      drain_results();
    end

    if (n_fail == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/dqsc_pkg.sv
hw/rtl/dqsc_core.sv
hw/rtl/dwell_qualified_state_confirmer.sv
bench/dqsc_result_checker.sv
bench/dwell_qualified_state_confirmer_tb.sv
